>>> sv/ssfd_pkg.sv
// Shared types, codes and tables for the seven-segment frame driver.
// Used by the front decoder, the command queue and the back end.
// No dependencies.
package ssfd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_DIGIT_COUNT  = 4;
  localparam int DEF_DEVICE_COUNT = 4;

  // Stream widths: the input word is 36 bits of fields padded to 40.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Widest digit position (four digits) and widest command argument (9999).
  localparam int POS_W       = 2;
  localparam int ARG_W       = 14;
  localparam int QUEUE_DEPTH = 2;

  // Operation codes of the input word.
  localparam logic [3:0] OP_INIT    = 4'd0;
  localparam logic [3:0] OP_SEND    = 4'd1;
  localparam logic [3:0] OP_NUMBER  = 4'd2;
  localparam logic [3:0] OP_DIGIT   = 4'd3;
  localparam logic [3:0] OP_DOT     = 4'd4;
  localparam logic [3:0] OP_MINUS   = 4'd5;
  localparam logic [3:0] OP_RAW     = 4'd6;
  localparam logic [3:0] OP_CLR_ALL = 4'd7;
  localparam logic [3:0] OP_CLR_ONE = 4'd8;

  // Bytes and patterns placed on the bus.
  localparam logic [7:0] SUBADDR_DIGITS = 8'h01;
  localparam logic [7:0] CTRL_BYTE0     = 8'h00;
  localparam logic [7:0] CTRL_BYTE1     = 8'h47;
  localparam logic [6:0] MINUS_PAT      = 7'h40;
  localparam logic [3:0] DIGIT_MAX      = 4'd9;

  // Command kinds after decoding; invalid requests never reach the queue.
  typedef enum logic [3:0] {
    K_INIT,
    K_SEND,
    K_NUMBER,
    K_NUM_OVF,
    K_DIGIT,
    K_DOT,
    K_DOT_CLR,
    K_MINUS,
    K_RAW,
    K_CLR_ALL,
    K_CLR_ONE
  } kind_t;

  // One queued command: kind, digit position and a shared argument
  // (number value, digit value or raw pattern in the low bits).
  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   pos;
    logic [ARG_W-1:0]   arg;
  } cmd_t;

  // Segments a..g for a decimal digit.
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

  // Bus address of each display device.
  function automatic logic [6:0] dev_addr(input logic [1:0] sel);
    logic [6:0] a;
    case (sel)
      2'd0:    a = 7'h38;
      2'd1:    a = 7'h39;
      2'd2:    a = 7'h40;
      default: a = 7'h41;
    endcase
    return a;
  endfunction

  // Power of ten, evaluated at elaboration only.
  function automatic int pow10(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

>>> sv/ssfd_front.sv
// Front end of the seven-segment frame driver: unpacks and classifies words.
// Drops requests that change nothing and hands the rest to the queue.
// Depends on ssfd_pkg.
module ssfd_front #(
  parameter int DIGIT_COUNT = ssfd_pkg::DEF_DIGIT_COUNT
) (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ssfd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output ssfd_pkg::cmd_t                   q_cmd
);
  import ssfd_pkg::*;

  localparam int LIM = pow10(DIGIT_COUNT);

  logic [3:0]  op;
  logic [7:0]  idx;
  logic [15:0] val;
  logic [7:0]  raw;
  logic        idx_ok;
  logic        keep;
  logic [3:0]  digit_sat;

  // Field unpacking.
  assign op  = in_tdata[3:0];
  assign idx = in_tdata[11:4];
  assign val = in_tdata[27:12];
  assign raw = in_tdata[35:28];

  assign idx_ok    = idx < 8'(DIGIT_COUNT);
  assign digit_sat = (val > 16'(DIGIT_MAX)) ? DIGIT_MAX : val[3:0];

  // Classification of the operation.
  always_comb begin
    q_cmd.kind = K_INIT;
    q_cmd.pos  = idx[POS_W-1:0];
    q_cmd.arg  = '0;
    keep       = 1'b1;
    case (op)
      OP_INIT: q_cmd.kind = K_INIT;
      OP_SEND: q_cmd.kind = K_SEND;
      OP_NUMBER: begin
        if (val > 16'(LIM - 1)) begin
          q_cmd.kind = K_NUM_OVF;
        end else begin
          q_cmd.kind = K_NUMBER;
          q_cmd.arg  = val[ARG_W-1:0];
        end
      end
      OP_DIGIT: begin
        q_cmd.kind = K_DIGIT;
        q_cmd.arg  = ARG_W'(digit_sat);
        keep       = idx_ok;
      end
      OP_DOT: q_cmd.kind = idx_ok ? K_DOT : K_DOT_CLR;
      OP_MINUS: begin
        q_cmd.kind = K_MINUS;
        keep       = idx_ok;
      end
      OP_RAW: begin
        q_cmd.kind = K_RAW;
        q_cmd.arg  = ARG_W'(raw);
        keep       = idx_ok;
      end
      OP_CLR_ALL: q_cmd.kind = K_CLR_ALL;
      OP_CLR_ONE: begin
        q_cmd.kind = K_CLR_ONE;
        keep       = idx_ok;
      end
      default: keep = 1'b0;
    endcase
  end

  // A word is taken whenever the queue has room; only useful ones are pushed.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && keep;

endmodule

>>> sv/ssfd_queue.sv
// Short command queue between the front decoder and the back end.
// Depends on ssfd_pkg.
module ssfd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssfd_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ssfd_pkg::cmd_t  pop_cmd
);
  import ssfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign pop_cmd = slot_r[rd_ptr_r];

  // Storage is written only on push.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/ssfd_back.sv
// Back end of the seven-segment frame driver: pattern buffer, digit-serial
// number conversion and the byte sequencer with its output register.
// Depends on ssfd_pkg.
module ssfd_back #(
  parameter int DIGIT_COUNT  = ssfd_pkg::DEF_DIGIT_COUNT,
  parameter int DEVICE_COUNT = ssfd_pkg::DEF_DEVICE_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_wdata,
  input  logic                              q_valid,
  input  ssfd_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import ssfd_pkg::*;

  localparam int PW        = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int MAX_BYTES = (2 * DEVICE_COUNT > DIGIT_COUNT + 1) ?
                             2 * DEVICE_COUNT : DIGIT_COUNT + 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  typedef enum logic [1:0] {S_IDLE, S_NUM, S_EMIT} state_t;

  state_t            state_r;
  logic [7:0]        pat_r [DIGIT_COUNT];
  logic [1:0]        sel_r;
  logic              is_init_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  end_cnt_r;
  logic [PW-1:0]     step_r;
  logic [ARG_W-1:0]  rem_r;
  logic              out_valid_r;
  logic [6:0]        out_addr_r;
  logic [7:0]        out_data_r;
  logic              out_end_r;
  logic              out_last_r;

  logic [ARG_W-1:0]  m_tab [DIGIT_COUNT];
  logic [ARG_W-1:0]  m_cur;
  logic [3:0]        digit;
  logic [ARG_W+2:0]  sub;
  logic [ARG_W-1:0]  rem_nxt;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     pat_idx;
  logic [1:0]        sel_sat;
  logic [6:0]        emit_addr;
  logic [7:0]        emit_data;
  logic              emit_end;
  logic              emit_last;
  logic              slot_free;
  logic              emit_go;

  // Place value of each digit position, most significant first.
  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_place
    assign m_tab[g] = ARG_W'(pow10(DIGIT_COUNT - 1 - g));
  end

  // One decimal digit per cycle: compare the remainder against nine multiples.
  assign m_cur = m_tab[step_r];
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({3'b000, rem_r} >= (ARG_W+3)'(k * m_cur)) begin
        digit = 4'(k);
        sub   = (ARG_W+3)'(k * m_cur);
      end
    end
    rem_nxt = ARG_W'({3'b000, rem_r} - sub);
  end

  // The device selector saturates at the last device present.
  assign sel_sat = (sel_r > 2'(DEVICE_COUNT - 1)) ? 2'(DEVICE_COUNT - 1) : sel_r;
  assign pos     = q_cmd.pos[PW-1:0];
  assign pat_idx = PW'(cnt_r - 1'b1);

  // Byte selected by the sequence counter.
  always_comb begin
    if (is_init_r) begin
      emit_addr = dev_addr(2'(cnt_r >> 1));
      emit_data = cnt_r[0] ? CTRL_BYTE1 : CTRL_BYTE0;
      emit_end  = cnt_r[0];
    end else if (cnt_r == '0) begin
      emit_addr = dev_addr(sel_sat);
      emit_data = SUBADDR_DIGITS;
      emit_end  = 1'b0;
    end else begin
      emit_addr = dev_addr(sel_sat);
      emit_data = pat_r[pat_idx];
      emit_end  = cnt_r == CNT_W'(DIGIT_COUNT);
    end
  end

  assign emit_last = cnt_r == end_cnt_r;
  assign slot_free = !out_valid_r || out_tready;
  assign emit_go   = (state_r == S_EMIT) && slot_free;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // Sequencer, pattern buffer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        pat_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        sel_r <= cfg_wdata;
      end
      // The output register fills on a new byte and empties when taken.
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              K_INIT: begin
                is_init_r <= 1'b1;
                cnt_r     <= '0;
                end_cnt_r <= CNT_W'(2 * DEVICE_COUNT - 1);
                state_r   <= S_EMIT;
              end
              K_SEND: begin
                is_init_r <= 1'b0;
                cnt_r     <= '0;
                end_cnt_r <= CNT_W'(DIGIT_COUNT);
                state_r   <= S_EMIT;
              end
              K_NUMBER: begin
                rem_r   <= q_cmd.arg;
                step_r  <= '0;
                state_r <= S_NUM;
              end
              K_NUM_OVF: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pat_r[i][6:0] <= seg_of(DIGIT_MAX);
                end
              end
              K_DIGIT: pat_r[pos][6:0] <= seg_of(q_cmd.arg[3:0]);
              K_DOT: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pat_r[i][7] <= PW'(i) == pos;
                end
              end
              K_DOT_CLR: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pat_r[i][7] <= 1'b0;
                end
              end
              K_MINUS: pat_r[pos][6:0] <= MINUS_PAT;
              K_RAW:   pat_r[pos] <= q_cmd.arg[7:0];
              K_CLR_ALL: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  pat_r[i] <= '0;
                end
              end
              K_CLR_ONE: pat_r[pos] <= '0;
              default: ;
            endcase
          end
        end
        S_NUM: begin
          pat_r[step_r][6:0] <= seg_of(digit);
          rem_r              <= rem_nxt;
          if (step_r == PW'(DIGIT_COUNT - 1)) begin
            state_r <= S_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_addr_r  <= emit_addr;
            out_data_r  <= emit_data;
            out_end_r   <= emit_end;
            out_last_r  <= emit_last;
            if (emit_last) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r, out_addr_r};
  assign out_tuser  = out_end_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/seven_segment_frame_driver_unit.sv
// Seven-segment frame driver. A command word is taken whenever the two-entry
// command queue has room and is registered in the queue before it reaches the
// back end. Buffer edits are made as the back end takes the command; a number
// write is taken from the queue and then converted one decimal digit per cycle
// by the shared digit compare unit. Send emits DIGIT_COUNT+1 bytes and init
// 2*DEVICE_COUNT bytes once the command is taken, one byte per cycle from the
// byte sequencer while the output register is being taken. The buffer and device
// selector reset to blank and zero; there is no clearing pass.
// Depends on ssfd_pkg, ssfd_front, ssfd_queue and ssfd_back.
module seven_segment_frame_driver_unit #(
  parameter int DIGIT_COUNT  = ssfd_pkg::DEF_DIGIT_COUNT,
  parameter int DEVICE_COUNT = ssfd_pkg::DEF_DEVICE_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: device_select.
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_wdata,
  // Commands. tdata from bit 0: operation[3:0], index[11:4], value[27:12],
  // raw_pattern[35:28], zero pad [39:36].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssfd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Bus bytes. tdata from bit 0: bus_address[6:0], data_byte[14:7], zero
  // pad [15]. tuser: transfer_end. tlast: last byte of the command.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import ssfd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Decoder.
  ssfd_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue.
  ssfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // Executor and byte sequencer.
  ssfd_back #(
    .DIGIT_COUNT  (DIGIT_COUNT),
    .DEVICE_COUNT (DEVICE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/ssfd_checker.sv
// Port-level checks for the seven-segment frame driver, bound to the top level.
// Depends on seven_segment_frame_driver_unit and ssfd_pkg.
module ssfd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ssfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              out_tlast
);

  // No byte is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("byte offered right after reset");

  // A stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled byte changed");

  // The last byte of a command always closes a bus transfer.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("command ended inside a transfer");

  // Bytes of one command follow without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a command's byte sequence");

endmodule

bind seven_segment_frame_driver_unit ssfd_checker u_ssfd_checker (.*);
